>>> design/uvsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsp_pkg
// Shared types and fixed widths of the texture-space surface point lookup.
// ----------------------------------------------------------------------------
package uvsp_pkg;

   localparam int POS_W       = 24;              // Q16.8 position
   localparam int TEX_W       = 16;              // Q0.16 texture coordinate
   localparam int EDGE_W      = TEX_W + 1;       // texture difference
   localparam int PROD_W      = 2 * EDGE_W + 1;  // sum or difference of edge products
   localparam int MAG_W       = 2 * EDGE_W;      // magnitude operand of mul unit
   localparam int MUL_HALF    = MAG_W / 2;
   localparam int MAG2_W      = 2 * MAG_W;
   localparam int SHIFT_W     = 5;
   localparam int DEG_W       = MAG2_W + (1 << SHIFT_W) - 1;
   localparam int TOL_W       = 16;
   localparam int NU_W        = PROD_W + 2;
   localparam int CMP_W       = NU_W + TOL_W + 1;
   localparam int WEIGHT_FRAC = 24;
   localparam int DIVN_W      = PROD_W + WEIGHT_FRAC;
   localparam int DIVC_W      = $clog2(DIVN_W);
   localparam int WGT_W       = WEIGHT_FRAC + 5;
   localparam int BPROD_W     = POS_W + WGT_W;
   localparam int ACC_W       = BPROD_W + 2;
   localparam int RND_W       = ACC_W - WEIGHT_FRAC;
   localparam int SAT_W       = 34;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 3 * POS_W + 2 * TEX_W;
   localparam int RSP_DATA_W  = 3 * POS_W;

   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_TOL     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGEN_SHIFT  = 1'd1;
   localparam logic [TOL_W-1:0]     EDGE_TOL_RESET   = 16'd66;
   localparam logic [SHIFT_W-1:0]   DEGEN_SHIFT_RESET = 5'd13;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_HIT  = 2'd1,
      STAT_MISS = 2'd2,
      STAT_FULL = 2'd3
   } status_type;

   // x in the lowest bits, matching the request data layout
   typedef struct packed {
      logic        [TEX_W-1:0] v;
      logic        [TEX_W-1:0] u;
      logic signed [POS_W-1:0] z;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] x;
   } vertex_type;

endpackage
`default_nettype wire

>>> design/uv_to_surface_point_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uv_to_surface_point_lookup
// Finds the first loaded triangle covering a texture coordinate and returns
// the barycentric blend of its mesh positions.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): tuser carries the command (clear, load vertex,
//    query), tdata the vertex position and texture coordinate. Every request
//    gives exactly one response on rsp_*: tuser = status, tdata = position.
//  - Loads write the vertex memory at the fill count; past 3*MAX_TRIANGLES
//    they are dropped with status full. Clear only resets the fill count.
//  - Clear and load go straight to ST_DONE, which loads the response.
//  - Query: triangles are fetched one vertex per cycle from a single-port
//    read memory and tested in order; each triangle passes through the
//    fetch (RD0 to RD3), edge setup, the 5 product steps, two passes
//    through the partial-product multiplier and three compare steps, of
//    which a thin triangle skips TOL1. A hit adds two bit-serial divisions
//    and weight sum; per coordinate it blends three terms, rounds, saturates.
//  - One request is processed at a time; a new one is taken while the
//    previous response still sits in the output register.
//  - A stalled response holds; the finished result of the next request
//    waits until the output register frees.
//  - Reset (synchronous) empties the table and restores the tolerance (66)
//    and degeneracy shift (13). The vertex memory is not cleared.
//  - csr_*: write-only registers, index 0 edge tolerance, 1 degeneracy shift.
// ----------------------------------------------------------------------------
module uv_to_surface_point_lookup #(
   parameter int MAX_TRIANGLES = 1024,
   parameter int POS_BITS      = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v
   input  wire logic [uvsp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command
   input  wire logic [1:0]                        req_tuser,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // surface_x, surface_y, surface_z
   output      logic [uvsp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output      logic [1:0]                        rsp_tuser,
   input  wire logic                              csr_we,
   input  wire logic [uvsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [uvsp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import uvsp_pkg::*;

   localparam int VTX_CAP = 3 * MAX_TRIANGLES;
   localparam int ADDR_W  = $clog2(VTX_CAP);
   localparam int CNT_W   = $clog2(VTX_CAP + 1);
   localparam logic signed [SAT_W-1:0] SAT_HI = (SAT_W'(1) <<< (POS_BITS - 1)) - SAT_W'(1);
   localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);
   localparam logic signed [WGT_W-1:0] W_ONE  = WGT_W'(1) <<< WEIGHT_FRAC;
   localparam logic signed [ACC_W-1:0] R_HALF = ACC_W'(1) <<< (WEIGHT_FRAC - 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_EDGE, ST_PROD, ST_MAG, ST_DD,
      ST_SIGN, ST_TOL1, ST_TOL2, ST_DIVV, ST_DIVW, ST_WSUM, ST_BLEND, ST_ROUND,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic [CNT_W-1:0]  count_ff, base_ff;
   logic [TEX_W-1:0]  pu_ff, pv_ff;
   vertex_type        va_ff, vb_ff, vc_ff, req_vtx, rd_vtx;
   logic signed [EDGE_W-1:0] e0u_ff, e0v_ff, e1u_ff, e1v_ff, qu_ff, qv_ff;
   logic [2:0]        step_ff;
   logic signed [PROD_W-1:0] den_ff, nv_ff, nw_ff;
   logic [MAG_W-1:0]  d00_ff, d11_ff;
   logic [MAG2_W-1:0] mag2_ff, dd_ff;
   logic signed [NU_W-1:0]  nu_ff;
   logic signed [CMP_W-1:0] lim_ff;
   logic signed [WGT_W-1:0] wu_ff, wv_ff, ww_ff;
   logic [1:0]        coord_ff, term_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [POS_W-1:0]  res_x_ff, res_y_ff, res_z_ff;
   status_type        res_stat_ff, rsp_stat_ff;
   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [TOL_W-1:0]  tol_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic              mul_go_ff, div_go_ff;

   logic              accept, full, wr_en, mul_done, div_done;
   cmd_type           cmd;
   logic [ADDR_W-1:0] rd_addr;
   logic signed [EDGE_W-1:0] m0a, m0b, m1a, m1b;
   logic              prod_sub;
   logic signed [MAG_W-1:0]  p0, p1;
   logic signed [PROD_W-1:0] psum;
   logic [MAG_W-1:0]  mag, mul_a, mul_b;
   logic [MAG2_W-1:0] mul_prod;
   logic [DEG_W-1:0]  deg_lhs;
   logic              degenerate;
   logic signed [CMP_W-1:0] tol_prod, nu_sh, nv_sh, nw_sh;
   logic              tol_fail;
   logic signed [PROD_W-1:0] div_src;
   logic [PROD_W-1:0] div_abs;
   logic [DIVN_W-1:0] div_num, div_quo;
   logic signed [WGT_W-1:0] wq, wsel;
   vertex_type        bvtx;
   logic signed [POS_W-1:0]  bpos;
   logic signed [BPROD_W-1:0] bprod;
   logic signed [ACC_W-1:0]  rnd_tmp;
   logic signed [SAT_W-1:0]  rnd;
   logic [POS_W-1:0]  sat;
   logic [CNT_W:0]    next_end;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign cmd        = cmd_type'(req_tuser);
   assign req_vtx    = req_tdata;
   assign full       = (count_ff == CNT_W'(VTX_CAP));
   assign wr_en      = accept && (cmd == CMD_LOAD) && !full;

   always_comb begin
      case (state_ff)
         ST_RD1:  rd_addr = ADDR_W'(base_ff + CNT_W'(1));
         ST_RD2:  rd_addr = ADDR_W'(base_ff + CNT_W'(2));
         default: rd_addr = ADDR_W'(base_ff);
      endcase
   end

   uvsp_store #(.DEPTH(VTX_CAP)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_vtx),
      .rd_addr (rd_addr),
      .rd_data (rd_vtx)
   );

   // two signed products per step: den, nv, nw, d00, d11
   always_comb begin
      case (step_ff)
         3'd0: begin
            m0a = e0u_ff; m0b = e1v_ff; m1a = e0v_ff; m1b = e1u_ff; prod_sub = 1'b1;
         end
         3'd1: begin
            m0a = qu_ff;  m0b = e1v_ff; m1a = qv_ff;  m1b = e1u_ff; prod_sub = 1'b1;
         end
         3'd2: begin
            m0a = e0u_ff; m0b = qv_ff;  m1a = e0v_ff; m1b = qu_ff;  prod_sub = 1'b1;
         end
         3'd3: begin
            m0a = e0u_ff; m0b = e0u_ff; m1a = e0v_ff; m1b = e0v_ff; prod_sub = 1'b0;
         end
         default: begin
            m0a = e1u_ff; m0b = e1u_ff; m1a = e1v_ff; m1b = e1v_ff; prod_sub = 1'b0;
         end
      endcase
   end

   assign p0   = m0a * m0b;
   assign p1   = m1a * m1b;
   assign psum = prod_sub ? PROD_W'(p0) - PROD_W'(p1) : PROD_W'(p0) + PROD_W'(p1);

   assign mag   = den_ff[PROD_W-1] ? MAG_W'(-den_ff) : MAG_W'(den_ff);
   assign mul_a = (state_ff == ST_MAG) ? mag : d00_ff;
   assign mul_b = (state_ff == ST_MAG) ? mag : d11_ff;

   uvsp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_go_ff),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // thin when cross^2 * 2^shift <= d00*d11
   assign deg_lhs    = DEG_W'(mag2_ff) << shift_ff;
   assign degenerate = deg_lhs <= DEG_W'(dd_ff);

   assign tol_prod = $signed({1'b0, tol_ff}) * den_ff;
   assign nu_sh    = CMP_W'(nu_ff) <<< TOL_W;
   assign nv_sh    = CMP_W'(nv_ff) <<< TOL_W;
   assign nw_sh    = CMP_W'(nw_ff) <<< TOL_W;
   assign tol_fail = (nu_sh < lim_ff) || (nv_sh < lim_ff) || (nw_sh < lim_ff);

   assign div_src = (state_ff == ST_DIVV) ? nv_ff : nw_ff;
   assign div_abs = div_src[PROD_W-1] ? PROD_W'(-div_src) : PROD_W'(div_src);
   assign div_num = {div_abs, {WEIGHT_FRAC{1'b0}}};

   uvsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (div_num),
      .den   (den_ff[MAG_W-1:0]),
      .done  (div_done),
      .quo   (div_quo)
   );

   // truncation toward zero: divide magnitudes, restore the sign
   assign wq = div_src[PROD_W-1] ? -$signed(div_quo[WGT_W-1:0])
                                 : $signed(div_quo[WGT_W-1:0]);

   always_comb begin
      case (term_ff)
         2'd0:    begin bvtx = va_ff; wsel = wu_ff; end
         2'd1:    begin bvtx = vb_ff; wsel = wv_ff; end
         default: begin bvtx = vc_ff; wsel = ww_ff; end
      endcase
      case (coord_ff)
         2'd0:    bpos = bvtx.x;
         2'd1:    bpos = bvtx.y;
         default: bpos = bvtx.z;
      endcase
   end

   // floor of the shifted sum keeps its sign
   assign bprod   = bpos * wsel;
   assign rnd_tmp = acc_ff + R_HALF;
   assign rnd     = SAT_W'($signed(rnd_tmp[ACC_W-1:WEIGHT_FRAC]));

   always_comb begin
      if (rnd > SAT_HI) begin
         sat = SAT_HI[POS_W-1:0];
      end else if (rnd < SAT_LO) begin
         sat = SAT_LO[POS_W-1:0];
      end else begin
         sat = rnd[POS_W-1:0];
      end
   end

   assign next_end = {1'b0, base_ff} + (CNT_W + 1)'(5);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         tol_ff       <= EDGE_TOL_RESET;
         shift_ff     <= DEGEN_SHIFT_RESET;
      end else begin
         mul_go_ff <= ((state_ff == ST_PROD) && (step_ff == 3'd4)) ||
                      ((state_ff == ST_MAG) && mul_done);
         div_go_ff <= ((state_ff == ST_TOL2) && !tol_fail) ||
                      ((state_ff == ST_DIVV) && div_done);
         if (rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_EDGE_TOL:    tol_ff   <= csr_wdata[TOL_W-1:0];
               CSR_DEGEN_SHIFT: shift_ff <= csr_wdata[SHIFT_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  res_x_ff    <= '0;
                  res_y_ff    <= '0;
                  res_z_ff    <= '0;
                  pu_ff       <= req_vtx.u;
                  pv_ff       <= req_vtx.v;
                  base_ff     <= '0;
                  case (cmd)
                     CMD_CLEAR: begin
                        count_ff    <= '0;
                        res_stat_ff <= STAT_OK;
                        state_ff    <= ST_DONE;
                     end
                     CMD_LOAD: begin
                        state_ff <= ST_DONE;
                        if (full) begin
                           res_stat_ff <= STAT_FULL;
                        end else begin
                           res_stat_ff <= STAT_OK;
                           count_ff    <= count_ff + CNT_W'(1);
                        end
                     end
                     CMD_QUERY: begin
                        res_stat_ff <= STAT_MISS;
                        state_ff    <= (count_ff >= CNT_W'(3)) ? ST_RD0 : ST_DONE;
                     end
                     default: begin
                        res_stat_ff <= STAT_OK;
                        state_ff    <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_RD0: state_ff <= ST_RD1;
            ST_RD1: begin
               va_ff    <= rd_vtx;
               state_ff <= ST_RD2;
            end
            ST_RD2: begin
               vb_ff    <= rd_vtx;
               state_ff <= ST_RD3;
            end
            ST_RD3: begin
               vc_ff    <= rd_vtx;
               state_ff <= ST_EDGE;
            end
            ST_EDGE: begin
               e0u_ff   <= $signed({1'b0, vb_ff.u}) - $signed({1'b0, va_ff.u});
               e0v_ff   <= $signed({1'b0, vb_ff.v}) - $signed({1'b0, va_ff.v});
               e1u_ff   <= $signed({1'b0, vc_ff.u}) - $signed({1'b0, va_ff.u});
               e1v_ff   <= $signed({1'b0, vc_ff.v}) - $signed({1'b0, va_ff.v});
               qu_ff    <= $signed({1'b0, pu_ff}) - $signed({1'b0, va_ff.u});
               qv_ff    <= $signed({1'b0, pv_ff}) - $signed({1'b0, va_ff.v});
               step_ff  <= '0;
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               step_ff <= step_ff + 3'd1;
               case (step_ff)
                  3'd0: den_ff <= psum;
                  3'd1: nv_ff  <= psum;
                  3'd2: nw_ff  <= psum;
                  3'd3: d00_ff <= psum[MAG_W-1:0];
                  default: begin
                     d11_ff    <= psum[MAG_W-1:0];
                     state_ff  <= ST_MAG;
                  end
               endcase
            end
            ST_MAG: begin
               if (mul_done) begin
                  mag2_ff   <= mul_prod;
                  state_ff  <= ST_DD;
               end
            end
            ST_DD: begin
               if (mul_done) begin
                  dd_ff    <= mul_prod;
                  state_ff <= ST_SIGN;
               end
            end
            ST_SIGN: begin
               if (degenerate) begin
                  state_ff <= ST_TOL2;   // skip path reused below
                  lim_ff   <= '0;
                  nu_ff    <= '0;
                  nv_ff    <= -PROD_W'(1);
               end else begin
                  state_ff <= ST_TOL1;
                  if (den_ff[PROD_W-1]) begin
                     den_ff <= -den_ff;
                     nv_ff  <= -nv_ff;
                     nw_ff  <= -nw_ff;
                  end
               end
            end
            ST_TOL1: begin
               nu_ff    <= NU_W'(den_ff) - NU_W'(nv_ff) - NU_W'(nw_ff);
               lim_ff   <= -tol_prod;
               state_ff <= ST_TOL2;
            end
            ST_TOL2: begin
               if (tol_fail) begin
                  if (next_end < (CNT_W + 1)'(count_ff)) begin
                     base_ff  <= base_ff + CNT_W'(3);
                     state_ff <= ST_RD0;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end else begin
                  state_ff  <= ST_DIVV;
               end
            end
            ST_DIVV: begin
               if (div_done) begin
                  wv_ff     <= wq;
                  state_ff  <= ST_DIVW;
               end
            end
            ST_DIVW: begin
               if (div_done) begin
                  ww_ff    <= wq;
                  state_ff <= ST_WSUM;
               end
            end
            ST_WSUM: begin
               wu_ff    <= W_ONE - wv_ff - ww_ff;
               coord_ff <= '0;
               term_ff  <= '0;
               state_ff <= ST_BLEND;
            end
            ST_BLEND: begin
               acc_ff <= ((term_ff == 2'd0) ? '0 : acc_ff) + ACC_W'(bprod);
               if (term_ff == 2'd2) begin
                  state_ff <= ST_ROUND;
               end else begin
                  term_ff <= term_ff + 2'd1;
               end
            end
            ST_ROUND: begin
               term_ff <= '0;
               case (coord_ff)
                  2'd0:    res_x_ff <= sat;
                  2'd1:    res_y_ff <= sat;
                  default: res_z_ff <= sat;
               endcase
               if (coord_ff == 2'd2) begin
                  res_stat_ff <= STAT_HIT;
                  state_ff    <= ST_DONE;
               end else begin
                  coord_ff <= coord_ff + 2'd1;
                  state_ff <= ST_BLEND;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_stat_ff  <= res_stat_ff;
                  rsp_data_ff  <= {res_z_ff, res_y_ff, res_x_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

`ifndef SYNTH
   a_store_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE))
      else $error("vertex write outside idle");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_LOAD && full) |=> (count_ff == CNT_W'(VTX_CAP)))
      else $error("dropped load changed fill count");

   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MAG || state_ff == ST_DD))
      else $error("multiplier result with no consumer");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVV || state_ff == ST_DIVW))
      else $error("divider result with no consumer");

   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && coord_ff == 2'd2) |=>
         (state_ff == ST_DONE && res_stat_ff == STAT_HIT))
      else $error("blend finished without hit status");
`endif

endmodule
`default_nettype wire

>>> design/uvsp_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsp_store
// Vertex memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module uvsp_store #(
   parameter int DEPTH  = 3072,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire uvsp_pkg::vertex_type wr_data,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output      uvsp_pkg::vertex_type rd_data
);
   import uvsp_pkg::*;

   vertex_type mem [DEPTH];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/uvsp_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsp_mul
// Unsigned 34x34 multiplier, one 17x17 partial product per cycle.
// ----------------------------------------------------------------------------
module uvsp_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [uvsp_pkg::MAG_W-1:0]    a,
   input  wire logic [uvsp_pkg::MAG_W-1:0]    b,
   output      logic                          done,
   output      logic [uvsp_pkg::MAG2_W-1:0]   prod
);
   import uvsp_pkg::*;

   logic [MAG_W-1:0]    a_ff, b_ff;
   logic [MAG2_W-1:0]   acc_ff;
   logic [1:0]          step_ff;
   logic                busy_ff, done_ff;
   logic [MUL_HALF-1:0] op_a, op_b;
   logic [MAG_W-1:0]    pp;
   logic [MAG2_W-1:0]   pp_sh;

   assign op_a = step_ff[1] ? a_ff[MAG_W-1:MUL_HALF] : a_ff[MUL_HALF-1:0];
   assign op_b = step_ff[0] ? b_ff[MAG_W-1:MUL_HALF] : b_ff[MUL_HALF-1:0];
   assign pp   = op_a * op_b;

   always_comb begin
      case (step_ff)
         2'd0:    pp_sh = MAG2_W'(pp);
         2'd3:    pp_sh = MAG2_W'(pp) << (2 * MUL_HALF);
         default: pp_sh = MAG2_W'(pp) << MUL_HALF;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= busy_ff && !start && (step_ff == 2'd3);
         if (start) begin
            a_ff    <= a;
            b_ff    <= b;
            acc_ff  <= '0;
            step_ff <= 2'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff  <= acc_ff + pp_sh;
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

>>> design/uvsp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module uvsp_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [uvsp_pkg::DIVN_W-1:0]   num,
   input  wire logic [uvsp_pkg::MAG_W-1:0]    den,
   output      logic                          done,
   output      logic [uvsp_pkg::DIVN_W-1:0]   quo
);
   import uvsp_pkg::*;

   logic [DIVN_W-1:0] num_ff;   // numerator shifts out, quotient shifts in
   logic [MAG_W-1:0]  den_ff, rem_ff;
   logic [DIVC_W-1:0] cnt_ff;
   logic              busy_ff, done_ff;
   logic [MAG_W:0]    trial;
   logic              fits;

   assign trial = {rem_ff, num_ff[DIVN_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == DIVC_W'(DIVN_W - 1));
         if (start) begin
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? MAG_W'(trial - {1'b0, den_ff}) : trial[MAG_W-1:0];
            num_ff <= {num_ff[DIVN_W-2:0], fits};
            cnt_ff <= cnt_ff + DIVC_W'(1);
            if (cnt_ff == DIVC_W'(DIVN_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule
`default_nettype wire

>>> tb/uv_to_surface_point_lookup_tb.sv
// ----------------------------------------------------------------------------
// uv_to_surface_point_lookup_tb
// Self-checking bench for the texture-space surface point lookup. Requests
// (clear, load vertex, query, unused command) go in with bursty timing. An
// in-bench model of the triangle table and the barycentric search predicts
// every response, and each response is compared field by field in order.
// ----------------------------------------------------------------------------
module uv_to_surface_point_lookup_tb;
   import uvsp_pkg::*;

   localparam int     MAX_TRI      = 1024;
   localparam int     POS_BITS     = 24;
   localparam int     VERTEX_CAP   = 3 * MAX_TRI;
   localparam longint WEIGHT_ONE   = 64'sd16777216;      // 1.0 in Q.24
   localparam int     IDLE_LIMIT   = 150000;             // limit on cycles with no handshake
   localparam int     RANDOM_REQS  = 50;
   localparam logic [1:0] CMD_UNUSED = 2'd3;            // no effect, status ok

   typedef struct {
      status_type  status;
      logic [23:0] x;
      logic [23:0] y;
      logic [23:0] z;
   } surface_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // pos_x, pos_y, pos_z, tex_u, tex_v
   logic [1:0] req_tuser = CMD_CLEAR;       // command
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // surface_x, surface_y, surface_z
   logic [1:0] rsp_tuser;                   // status
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_EDGE_TOL;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   uv_to_surface_point_lookup #(
      .MAX_TRIANGLES(MAX_TRI),
      .POS_BITS(POS_BITS)
   ) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow table and registers
   // ---------------------------------------------------------------------
   int          shadow_x [VERTEX_CAP];
   int          shadow_y [VERTEX_CAP];
   int          shadow_z [VERTEX_CAP];
   int          shadow_u [VERTEX_CAP];
   int          shadow_v [VERTEX_CAP];
   int          fill_count = 0;
   int          edge_tol   = 66;
   int          deg_shift  = 13;

   surface_result_type surface_expected[$];
   int          mismatches = 0;
   int          burst_left = 0;
   int          total_sent = 0;

   // Weighted sum of three Q16.8 coordinates, Q.24 weights; round half up,
   // then clamp to the signed position range.
   function automatic logic [23:0] blend_coord(longint p0, longint p1, longint p2,
                                               longint w0, longint w1, longint w2);
      longint s, q, hi, lo;
      s = p0 * w0 + p1 * w1 + p2 * w2 + WEIGHT_ONE / 2;
      q = s / WEIGHT_ONE;
      if ((s % WEIGHT_ONE) != 0 && s < 0) q = q - 1;
      hi = (longint'(1) <<< (POS_BITS - 1)) - 1;
      lo = -hi - 1;
      if (q > hi) q = hi;
      if (q < lo) q = lo;
      return q[23:0];
   endfunction

   // Barycentric test of the triangle starting at vertex base; fills res on hit
   function automatic bit triangle_covers(int base, longint pu, longint pv,
                                          output surface_result_type res);
      longint au, av, e0u, e0v, e1u, e1v, qu, qv;
      longint den, nv, nw, nu, lim, wv, ww, d00, d11;
      logic [127:0] area_sq, edge_prod;
      res = '{STAT_MISS, '0, '0, '0};
      au  = shadow_u[base];
      av  = shadow_v[base];
      e0u = shadow_u[base + 1] - au;
      e0v = shadow_v[base + 1] - av;
      e1u = shadow_u[base + 2] - au;
      e1v = shadow_v[base + 2] - av;
      qu  = pu - au;
      qv  = pv - av;
      den = e0u * e1v - e0v * e1u;
      nv  = qu * e1v - qv * e1u;
      nw  = e0u * qv - e0v * qu;
      d00 = e0u * e0u + e0v * e0v;
      d11 = e1u * e1u + e1v * e1v;
      // thin check: den^2 * 2^shift must exceed d00*d11
      area_sq   = (den < 0) ? -den : den;
      area_sq   = area_sq * area_sq;
      area_sq   = area_sq << deg_shift;
      edge_prod = d00;
      edge_prod = edge_prod * d11;
      if (area_sq <= edge_prod) return 1'b0;
      if (den < 0) begin
         den = -den;
         nv  = -nv;
         nw  = -nw;
      end
      nu  = den - nv - nw;
      lim = -(longint'(edge_tol) * den);
      if (nu * 65536 < lim || nv * 65536 < lim || nw * 65536 < lim) return 1'b0;
      wv = (nv * WEIGHT_ONE) / den;
      ww = (nw * WEIGHT_ONE) / den;
      res.status = STAT_HIT;
      res.x = blend_coord(shadow_x[base], shadow_x[base + 1], shadow_x[base + 2],
                          WEIGHT_ONE - wv - ww, wv, ww);
      res.y = blend_coord(shadow_y[base], shadow_y[base + 1], shadow_y[base + 2],
                          WEIGHT_ONE - wv - ww, wv, ww);
      res.z = blend_coord(shadow_z[base], shadow_z[base + 1], shadow_z[base + 2],
                          WEIGHT_ONE - wv - ww, wv, ww);
      return 1'b1;
   endfunction

   // Applies one request to the shadow table and returns the response it gives
   function automatic surface_result_type lookup_predict(logic [1:0] cmd, vertex_type vin);
      surface_result_type res, hit;
      int tris;
      res = '{STAT_OK, '0, '0, '0};
      case (cmd)
         CMD_CLEAR: fill_count = 0;
         CMD_LOAD: begin
            if (fill_count >= VERTEX_CAP) begin
               res.status = STAT_FULL;
            end else begin
               shadow_x[fill_count] = $signed(vin.x);
               shadow_y[fill_count] = $signed(vin.y);
               shadow_z[fill_count] = $signed(vin.z);
               shadow_u[fill_count] = vin.u;
               shadow_v[fill_count] = vin.v;
               fill_count++;
            end
         end
         CMD_QUERY: begin
            res.status = STAT_MISS;
            tris = fill_count / 3;   // a partial triangle never takes part
            for (int t = 0; t < tris; t++) begin
               if (triangle_covers(3 * t, vin.u, vin.v, hit)) begin
                  res = hit;
                  break;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Bursty sender: random burst lengths, random gaps between bursts.
   task automatic send_req(logic [1:0] cmd, vertex_type vin);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= vin;
      do @(posedge clock); while (!req_tready);
      surface_expected.push_back(lookup_predict(cmd, vin));
      burst_left--;
   endtask

   task automatic send_vertex(int x, int y, int z, int u, int v);
      vertex_type vin;
      vin.x = x[23:0];
      vin.y = y[23:0];
      vin.z = z[23:0];
      vin.u = u[15:0];
      vin.v = v[15:0];
      send_req(CMD_LOAD, vin);
   endtask

   task automatic send_query(int u, int v);
      vertex_type vin;
      vin.x = 24'($urandom);   // ignored on query, still toggles the bits
      vin.y = 24'($urandom);
      vin.z = 24'($urandom);
      vin.u = u[15:0];
      vin.v = v[15:0];
      send_req(CMD_QUERY, vin);
   endtask

   task automatic send_plain(logic [1:0] cmd);
      vertex_type vin;
      vin = REQ_DATA_W'({$urandom, $urandom, $urandom, $urandom});
      send_req(cmd, vin);
   endtask

   // Drop valid and wait out every pending response.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (surface_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Registers only change while the block is idle.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_EDGE_TOL) edge_tol = value & 16'hFFFF;
      else deg_shift = value & 5'h1F;
   endtask

   // Point inside (or on the edge of) triangle t of the table
   task automatic query_inside(int t);
      int a, r1, r2, pu, pv;
      a  = 3 * t;
      r1 = $urandom_range(0, 256);
      r2 = $urandom_range(0, 256 - r1);
      pu = shadow_u[a] + (r1 * (shadow_u[a + 1] - shadow_u[a])
                          + r2 * (shadow_u[a + 2] - shadow_u[a])) / 256;
      pv = shadow_v[a] + (r1 * (shadow_v[a + 1] - shadow_v[a])
                          + r2 * (shadow_v[a + 2] - shadow_v[a])) / 256;
      send_query(pu, pv);
   endtask

   // One table build followed by queries: clear, 1..4 triangles, maybe a
   // partial triangle, then mostly covered points with some noise.
   task automatic run_lookup_round();
      int ntri, a;
      send_plain(CMD_CLEAR);
      ntri = $urandom_range(1, 4);
      for (int k = 0; k < 3 * ntri; k++) begin
         a = 3 * (k / 3);
         if (k % 3 == 2 && $urandom_range(0, 5) == 0)   // thin sliver
            send_vertex($urandom, $urandom, $urandom,
                        (shadow_u[a] + shadow_u[a + 1]) / 2 + $urandom_range(0, 1),
                        (shadow_v[a] + shadow_v[a + 1]) / 2);
         else
            send_vertex($urandom, $urandom, $urandom,
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2))
            send_vertex($urandom, $urandom, $urandom,
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
      repeat ($urandom_range(4, 8)) begin
         case ($urandom_range(0, 9))
            0:       send_plain(CMD_UNUSED);
            1, 2:    send_query($urandom_range(0, 65535), $urandom_range(0, 65535));
            default: query_inside($urandom_range(0, ntri - 1));
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Empty table, unused command, clear
   task automatic test_empty_table();
      send_query(0, 0);
      send_query(65535, 65535);
      send_plain(CMD_UNUSED);
      send_plain(CMD_CLEAR);
      send_query(32768, 1);
   endtask

   // Fixed triangles: corners, outside, degenerate skip, partial triangle,
   // position extremes, the widest and the narrowest tolerance
   task automatic test_directed_shapes();
      send_plain(CMD_CLEAR);
      // zero-area triangle first: must be skipped
      send_vertex(1, 2, 3, 0, 0);
      send_vertex(4, 5, 6, 100, 100);
      send_vertex(7, 8, 9, 200, 200);
      // full-range triangle with extreme positions
      send_vertex(8388607, -8388608, 8388607, 0, 0);
      send_vertex(-8388608, 8388607, -1, 65535, 0);
      send_vertex(0, -1, -8388608, 0, 65535);
      // partial triangle: two extra vertices
      send_vertex(100, 100, 100, 65535, 65535);
      send_vertex(200, 200, 200, 65000, 65535);
      send_query(0, 0);
      send_query(65535, 0);
      send_query(0, 65535);
      send_query(100, 100);
      send_query(21845, 21845);
      send_query(65535, 65535);   // only the partial triangle is near: miss
      send_query(32768, 32768);   // just past the hypotenuse
      write_csr(CSR_EDGE_TOL, 65535);
      send_query(65535, 65535);   // outside even the widest tolerance: miss
      send_query(40000, 40000);
      write_csr(CSR_EDGE_TOL, 0);
      send_query(32767, 32767);
      send_query(32768, 32768);
      write_csr(CSR_EDGE_TOL, 66);
   endtask

   // Register extremes and one middle setting, each with a table build
   task automatic test_register_sweep();
      int tol_set [4]   = '{0, 65535, 0, 1000};
      int shift_set [4] = '{0, 31, 31, 5};
      for (int i = 0; i < 4; i++) begin
         write_csr(CSR_EDGE_TOL, tol_set[i]);
         write_csr(CSR_DEGEN_SHIFT, shift_set[i]);
         run_lookup_round();
      end
      write_csr(CSR_EDGE_TOL, 66);
      write_csr(CSR_DEGEN_SHIFT, 13);
   endtask

   // Random rounds; settings change between some rounds
   task automatic test_random_lookups();
      int sent_start;
      sent_start = total_sent;
      while (total_sent - sent_start < RANDOM_REQS) begin
         if ($urandom_range(0, 2) == 0) begin
            write_csr(CSR_EDGE_TOL, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 65535) : $urandom_range(0, 300));
            write_csr(CSR_DEGEN_SHIFT, $urandom_range(0, 31));
         end
         if ($urandom_range(0, 4) == 0) wait_idle();   // drain mid-stream
         run_lookup_round();
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: stall pattern, checker, watchdog
   // ---------------------------------------------------------------------
   logic [6:0] stall_phase = '0;
   logic [1:0] stall_mode  = '0;
   int         idle_cycles = 0;
   surface_result_type head;

   always @(posedge clock) if (req_tvalid && req_tready) total_sent <= total_sent + 1;

   // Mode is redrawn whenever the 7-bit phase wraps: always ready, coin toss, or ready when phase[2:0] is zero.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase == '0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= (stall_phase[2:0] == 3'd0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (surface_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response with none pending: status %0d data %h",
                        rsp_tuser, rsp_tdata);
         end else begin
            head = surface_expected.pop_front();
            if (rsp_tuser !== head.status || rsp_tdata[23:0] !== head.x ||
                rsp_tdata[47:24] !== head.y || rsp_tdata[71:48] !== head.z) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("bad response: got status %0d xyz %h %h %h, want %0d %h %h %h",
                           rsp_tuser, rsp_tdata[23:0], rsp_tdata[47:24], rsp_tdata[71:48],
                           head.status, head.x, head.y, head.z);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("uv_to_surface_point_lookup: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_directed_shapes();
      test_register_sweep();
      test_random_lookups();
      wait_idle();
      repeat (300) @(posedge clock);   // catch any stray response
      if (mismatches == 0 && surface_expected.size() == 0) begin
         $display("uv_to_surface_point_lookup: match");
      end else begin
         $display("uv_to_surface_point_lookup: mismatch");
      end
      $finish;
   end

endmodule

>>> files.f
design/uvsp_pkg.sv
design/uvsp_store.sv
design/uvsp_mul.sv
design/uvsp_div.sv
design/uv_to_surface_point_lookup.sv
tb/uv_to_surface_point_lookup_tb.sv
